// File: sv/tvsg_pkg.sv
// ----------------------------------------------------------------------------
// Velocity safety gate package
// Shared word types, operation codes, register indexes and sector constants.
// ----------------------------------------------------------------------------
package tvsg_pkg;

  localparam int OP_W        = 4;
  localparam int BEAM_IDX_W  = 7;
  localparam int RANGE_W     = 16;
  localparam int SPEED_W     = 10;
  localparam int VEL_W       = 11;
  localparam int AGE_W       = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Scan geometry.
  localparam int BEAMS       = 128;
  localparam int FRONT_FIRST = 58;
  localparam int FRONT_END   = 70;
  localparam int REAR_HALF   = 6;
  localparam int SCAN_IDX_W  = 11;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 4'd0,
    OP_FWD      = 4'd1,
    OP_BACK     = 4'd2,
    OP_CW       = 4'd3,
    OP_CCW      = 4'd4,
    OP_STOP     = 4'd5,
    OP_LIN_UP   = 4'd6,
    OP_LIN_DOWN = 4'd7,
    OP_ANG_UP   = 4'd8,
    OP_ANG_DOWN = 4'd9,
    OP_BEAM     = 4'd10
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT_TICKS = 3'd0,
    CFG_MAX_LINEAR    = 3'd1,
    CFG_MAX_ANGULAR   = 3'd2,
    CFG_LINEAR_STEP   = 3'd3,
    CFG_ANGULAR_STEP  = 3'd4,
    CFG_SAFETY_DIST   = 3'd5
  } cfg_idx_t;

  localparam logic [AGE_W-1:0]   RST_TIMEOUT_TICKS = 8'd10;
  localparam logic [SPEED_W-1:0] RST_MAX_LINEAR    = 10'd1000;
  localparam logic [SPEED_W-1:0] RST_MAX_ANGULAR   = 10'd1000;
  localparam logic [SPEED_W-1:0] RST_LINEAR_STEP   = 10'd50;
  localparam logic [SPEED_W-1:0] RST_ANGULAR_STEP  = 10'd50;
  localparam logic [RANGE_W-1:0] RST_SAFETY_DIST   = 16'd500;

  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [BEAM_IDX_W-1:0] beam_index;
    logic [RANGE_W-1:0]    beam_range_mm;
    logic                  beam_last;
  } in_word_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] linear_cmd;
    logic signed [VEL_W-1:0] angular_cmd;
    logic                    unsafe_stop;
    logic                    timed_out;
  } out_word_t;

  typedef struct packed {
    logic [AGE_W-1:0]   timeout_ticks;
    logic [SPEED_W-1:0] max_linear_speed;
    logic [SPEED_W-1:0] max_angular_speed;
    logic [SPEED_W-1:0] linear_step;
    logic [SPEED_W-1:0] angular_step;
    logic [RANGE_W-1:0] safety_distance_mm;
  } cfg_t;

  function automatic logic [SPEED_W-1:0] speed_up(
    input logic [SPEED_W-1:0] speed,
    input logic [SPEED_W-1:0] step,
    input logic [SPEED_W-1:0] ceiling
  );
    logic [SPEED_W:0] sum;
    sum = {1'b0, speed} + {1'b0, step};
    if (speed < ceiling && sum <= {1'b0, ceiling}) begin
      return sum[SPEED_W-1:0];
    end
    return ceiling;
  endfunction

  function automatic logic [SPEED_W-1:0] speed_down(
    input logic [SPEED_W-1:0] speed,
    input logic [SPEED_W-1:0] step
  );
    if (speed >= step) begin
      return speed - step;
    end
    return '0;
  endfunction

endpackage

// File: sv/teleop_velocity_safety_gate.sv
// ----------------------------------------------------------------------------
// Teleoperation velocity safety gate
// Operator commands, laser beams and ticks in; gated velocity words out.
// ----------------------------------------------------------------------------
// The block takes one input word every clock cycle while in_stall is low. An
// accepted word sits in the input register, where it updates the speed, velocity,
// command age and scan state; a tick also loads its result word into the output
// register, so a result reaches the out_ port through the input register and
// then the output register. Commands and beams give no result. A tick waits in the
// input register only while the output register holds a word that is being
// stalled, and the input is stalled for as long as it waits; otherwise words
// pass at one per cycle. Configuration writes are taken every cycle
// (cfg_ready is always high) and are meant for idle periods.
module teleop_velocity_safety_gate
  import tvsg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  in_word_t  stage_word_r;
  logic      stage_valid_r, stage_valid_nxt;
  out_word_t out_word_r;
  out_word_t result;
  logic      out_valid_r, out_valid_nxt;
  logic      stage_tick;
  logic      out_free;
  logic      step_en;
  logic      in_take;

  assign cfg_ready = 1'b1;

  tvsg_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign stage_tick = stage_word_r.op == OP_TICK;
  assign out_free   = !out_valid_r || !out_stall;
  assign step_en    = stage_valid_r && (!stage_tick || out_free);
  assign in_stall   = stage_valid_r && !step_en;
  assign in_take    = in_valid && !in_stall;

  tvsg_state u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .word    (stage_word_r),
    .cfg     (cfg),
    .result  (result)
  );

  always_comb begin
    stage_valid_nxt = in_take || (stage_valid_r && !step_en);
    if (step_en && stage_tick) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_word_r <= in_word;
    end
    if (step_en && stage_tick) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_word_r))
    else $error("stalled result word was lost or changed");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_word_r.timed_out && out_word_r.unsafe_stop))
    else $error("timeout and unsafe stop flagged together");

  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid_r && !step_en |=> stage_valid_r && $stable(stage_word_r))
    else $error("waiting input word was dropped");

endmodule

// File: sv/tvsg_cfg_regs.sv
// ----------------------------------------------------------------------------
// Velocity safety gate configuration registers
// Holds the six tuning registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module tvsg_cfg_regs
  import tvsg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_TIMEOUT_TICKS: cfg_nxt.timeout_ticks      = wr_data[AGE_W-1:0];
        CFG_MAX_LINEAR:    cfg_nxt.max_linear_speed   = wr_data[SPEED_W-1:0];
        CFG_MAX_ANGULAR:   cfg_nxt.max_angular_speed  = wr_data[SPEED_W-1:0];
        CFG_LINEAR_STEP:   cfg_nxt.linear_step        = wr_data[SPEED_W-1:0];
        CFG_ANGULAR_STEP:  cfg_nxt.angular_step       = wr_data[SPEED_W-1:0];
        CFG_SAFETY_DIST:   cfg_nxt.safety_distance_mm = wr_data[RANGE_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks      <= RST_TIMEOUT_TICKS;
      cfg_r.max_linear_speed   <= RST_MAX_LINEAR;
      cfg_r.max_angular_speed  <= RST_MAX_ANGULAR;
      cfg_r.linear_step        <= RST_LINEAR_STEP;
      cfg_r.angular_step       <= RST_ANGULAR_STEP;
      cfg_r.safety_distance_mm <= RST_SAFETY_DIST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/tvsg_state.sv
// ----------------------------------------------------------------------------
// Velocity safety gate state update
// Speeds, velocities, command age and scan flags, updated by one word a cycle while step_en is high.
// ----------------------------------------------------------------------------
module tvsg_state
  import tvsg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_word_t  word,
  input  cfg_t      cfg,
  output out_word_t result
);

  logic [SPEED_W-1:0]      lin_speed_r, lin_speed_nxt;
  logic [SPEED_W-1:0]      ang_speed_r, ang_speed_nxt;
  logic signed [VEL_W-1:0] lin_vel_r, lin_vel_nxt;
  logic signed [VEL_W-1:0] ang_vel_r, ang_vel_nxt;
  logic [AGE_W-1:0]        age_r, age_nxt;
  logic                    front_pend_r, front_pend_nxt;
  logic                    rear_pend_r, rear_pend_nxt;
  logic                    front_blk_r, front_blk_nxt;
  logic                    rear_blk_r, rear_blk_nxt;
  logic                    scan_seen_r, scan_seen_nxt;

  logic [SCAN_IDX_W-1:0] idx;
  logic                  hit;
  logic                  in_front;
  logic                  in_rear;
  logic                  timeout;
  logic                  unsafe;

  assign idx      = {{(SCAN_IDX_W-BEAM_IDX_W){1'b0}}, word.beam_index};
  assign hit      = (idx < SCAN_IDX_W'(BEAMS)) && (word.beam_range_mm < cfg.safety_distance_mm);
  assign in_front = (idx >= SCAN_IDX_W'(FRONT_FIRST)) && (idx < SCAN_IDX_W'(FRONT_END));
  assign in_rear  = (idx < SCAN_IDX_W'(REAR_HALF)) ||
                    ((idx + SCAN_IDX_W'(REAR_HALF)) >= SCAN_IDX_W'(BEAMS));

  assign timeout  = age_r > cfg.timeout_ticks;

  always_comb begin
    priority if (!scan_seen_r) begin
      unsafe = 1'b1;
    end else if (!lin_vel_r[VEL_W-1]) begin
      unsafe = front_blk_r;
    end else begin
      unsafe = rear_blk_r;
    end
  end

  always_comb begin
    lin_speed_nxt  = lin_speed_r;
    ang_speed_nxt  = ang_speed_r;
    lin_vel_nxt    = lin_vel_r;
    ang_vel_nxt    = ang_vel_r;
    age_nxt        = age_r;
    front_pend_nxt = front_pend_r;
    rear_pend_nxt  = rear_pend_r;
    front_blk_nxt  = front_blk_r;
    rear_blk_nxt   = rear_blk_r;
    scan_seen_nxt  = scan_seen_r;
    result.linear_cmd  = lin_vel_r;
    result.angular_cmd = ang_vel_r;
    result.unsafe_stop = 1'b0;
    result.timed_out   = 1'b0;

    unique case (word.op)
      OP_TICK: begin
        if (timeout) begin
          lin_vel_nxt      = '0;
          ang_vel_nxt      = '0;
          result.timed_out = 1'b1;
        end else begin
          result.unsafe_stop = unsafe;
          if (unsafe) begin
            lin_vel_nxt = '0;
          end
        end
        if (age_r != AGE_MAX) begin
          age_nxt = age_r + 1'b1;
        end
        result.linear_cmd  = lin_vel_nxt;
        result.angular_cmd = ang_vel_nxt;
      end
      OP_FWD: begin
        lin_vel_nxt = $signed({1'b0, lin_speed_r});
        ang_vel_nxt = '0;
        age_nxt     = '0;
      end
      OP_BACK: begin
        lin_vel_nxt = -$signed({1'b0, lin_speed_r});
        ang_vel_nxt = '0;
        age_nxt     = '0;
      end
      OP_CW: begin
        ang_vel_nxt = $signed({1'b0, ang_speed_r});
        lin_vel_nxt = '0;
        age_nxt     = '0;
      end
      OP_CCW: begin
        ang_vel_nxt = -$signed({1'b0, ang_speed_r});
        lin_vel_nxt = '0;
        age_nxt     = '0;
      end
      OP_STOP: begin
        lin_speed_nxt = '0;
        ang_speed_nxt = '0;
        lin_vel_nxt   = '0;
        ang_vel_nxt   = '0;
        age_nxt       = '0;
      end
      OP_LIN_UP: begin
        lin_speed_nxt = speed_up(lin_speed_r, cfg.linear_step, cfg.max_linear_speed);
        age_nxt       = '0;
      end
      OP_LIN_DOWN: begin
        lin_speed_nxt = speed_down(lin_speed_r, cfg.linear_step);
        age_nxt       = '0;
      end
      OP_ANG_UP: begin
        ang_speed_nxt = speed_up(ang_speed_r, cfg.angular_step, cfg.max_angular_speed);
        age_nxt       = '0;
      end
      OP_ANG_DOWN: begin
        ang_speed_nxt = speed_down(ang_speed_r, cfg.angular_step);
        age_nxt       = '0;
      end
      OP_BEAM: begin
        if (hit && in_front) begin
          front_pend_nxt = 1'b1;
        end
        if (hit && in_rear) begin
          rear_pend_nxt = 1'b1;
        end
        if (word.beam_last) begin
          front_blk_nxt  = front_pend_nxt;
          rear_blk_nxt   = rear_pend_nxt;
          front_pend_nxt = 1'b0;
          rear_pend_nxt  = 1'b0;
          scan_seen_nxt  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_speed_r  <= '0;
      ang_speed_r  <= '0;
      lin_vel_r    <= '0;
      ang_vel_r    <= '0;
      age_r        <= AGE_MAX;
      front_pend_r <= 1'b0;
      rear_pend_r  <= 1'b0;
      front_blk_r  <= 1'b0;
      rear_blk_r   <= 1'b0;
      scan_seen_r  <= 1'b0;
    end else if (step_en) begin
      lin_speed_r  <= lin_speed_nxt;
      ang_speed_r  <= ang_speed_nxt;
      lin_vel_r    <= lin_vel_nxt;
      ang_vel_r    <= ang_vel_nxt;
      age_r        <= age_nxt;
      front_pend_r <= front_pend_nxt;
      rear_pend_r  <= rear_pend_nxt;
      front_blk_r  <= front_blk_nxt;
      rear_blk_r   <= rear_blk_nxt;
      scan_seen_r  <= scan_seen_nxt;
    end
  end

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && word.op == OP_STOP |=>
      lin_speed_r == '0 && ang_speed_r == '0 && lin_vel_r == '0 && ang_vel_r == '0)
    else $error("stop did not clear speeds and velocities");

  a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && word.op == OP_TICK && timeout |->
      result.linear_cmd == '0 && result.angular_cmd == '0 && !result.unsafe_stop)
    else $error("timed out tick gave a non-zero velocity");

  a_scan_latch: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && word.op == OP_BEAM && word.beam_last |=>
      scan_seen_r && !front_pend_r && !rear_pend_r)
    else $error("last beam did not latch the scan");

  a_age_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (word.op == OP_FWD || word.op == OP_LIN_UP || word.op == OP_ANG_DOWN) |=>
      age_r == '0)
    else $error("command did not restart the command age");

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Velocity safety gate testbench
// Drives operator commands, laser beam words and ticks into the gate under
// several register settings, with random gaps and stalls on both channels.
// A scoreboard class mirrors the gate's state, predicts the result word of
// every accepted tick and checks each result word against the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import tvsg_pkg::*;

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 315;
  localparam int HOLD_CYCLES     = 400;
  localparam int IDLE_LIMIT      = 4000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int END_CYCLES      = 10;

  class cmd_tracker;
    logic [AGE_W-1:0]        cfg_timeout;
    logic [SPEED_W-1:0]      cfg_max_lin;
    logic [SPEED_W-1:0]      cfg_max_ang;
    logic [SPEED_W-1:0]      cfg_lin_step;
    logic [SPEED_W-1:0]      cfg_ang_step;
    logic [RANGE_W-1:0]      cfg_safety;
    logic [SPEED_W-1:0]      lin_speed;
    logic [SPEED_W-1:0]      ang_speed;
    logic signed [VEL_W-1:0] lin_vel;
    logic signed [VEL_W-1:0] ang_vel;
    logic [AGE_W-1:0]        age;
    bit                      front_pend;
    bit                      rear_pend;
    bit                      front_blk;
    bit                      rear_blk;
    bit                      scan_seen;
    out_word_t               due_cmds[$];
    int                      errors;

    function new();
      cfg_timeout  = RST_TIMEOUT_TICKS;
      cfg_max_lin  = RST_MAX_LINEAR;
      cfg_max_ang  = RST_MAX_ANGULAR;
      cfg_lin_step = RST_LINEAR_STEP;
      cfg_ang_step = RST_ANGULAR_STEP;
      cfg_safety   = RST_SAFETY_DIST;
      lin_speed    = '0;
      ang_speed    = '0;
      lin_vel      = '0;
      ang_vel      = '0;
      age          = AGE_MAX;
      front_pend   = 1'b0;
      rear_pend    = 1'b0;
      front_blk    = 1'b0;
      rear_blk     = 1'b0;
      scan_seen    = 1'b0;
      errors       = 0;
    endfunction

    function int pending();
      return due_cmds.size();
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_TIMEOUT_TICKS: cfg_timeout  = d[AGE_W-1:0];
        CFG_MAX_LINEAR:    cfg_max_lin  = d[SPEED_W-1:0];
        CFG_MAX_ANGULAR:   cfg_max_ang  = d[SPEED_W-1:0];
        CFG_LINEAR_STEP:   cfg_lin_step = d[SPEED_W-1:0];
        CFG_ANGULAR_STEP:  cfg_ang_step = d[SPEED_W-1:0];
        CFG_SAFETY_DIST:   cfg_safety   = d[RANGE_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [SPEED_W-1:0] raise_speed(logic [SPEED_W-1:0] speed,
                                             logic [SPEED_W-1:0] step,
                                             logic [SPEED_W-1:0] ceiling);
      logic [SPEED_W:0] next;
      if (speed >= ceiling) begin
        return ceiling;
      end
      next = {1'b0, speed} + {1'b0, step};
      if (next > {1'b0, ceiling}) begin
        return ceiling;
      end
      return next[SPEED_W-1:0];
    endfunction

    function logic [SPEED_W-1:0] lower_speed(logic [SPEED_W-1:0] speed,
                                             logic [SPEED_W-1:0] step);
      if (speed >= step) begin
        return speed - step;
      end
      return '0;
    endfunction

    function void take_word(in_word_t w);
      out_word_t r;
      bit        unsafe;
      r = '0;
      unsafe = 1'b0;
      case (w.op)
        OP_TICK: begin
          if (age > cfg_timeout) begin
            lin_vel = '0;
            ang_vel = '0;
            r.timed_out = 1'b1;
          end else begin
            if (!scan_seen) begin
              unsafe = 1'b1;
            end else if (!lin_vel[VEL_W-1]) begin
              unsafe = front_blk;
            end else begin
              unsafe = rear_blk;
            end
            if (unsafe) begin
              lin_vel = '0;
            end
            r.unsafe_stop = unsafe;
          end
          if (age != AGE_MAX) begin
            age = age + 1'b1;
          end
          r.linear_cmd  = lin_vel;
          r.angular_cmd = ang_vel;
          due_cmds.push_back(r);
        end
        OP_FWD: begin
          lin_vel = {1'b0, lin_speed};
          ang_vel = '0;
          age = '0;
        end
        OP_BACK: begin
          lin_vel = -{1'b0, lin_speed};
          ang_vel = '0;
          age = '0;
        end
        OP_CW: begin
          ang_vel = {1'b0, ang_speed};
          lin_vel = '0;
          age = '0;
        end
        OP_CCW: begin
          ang_vel = -{1'b0, ang_speed};
          lin_vel = '0;
          age = '0;
        end
        OP_STOP: begin
          lin_speed = '0;
          ang_speed = '0;
          lin_vel = '0;
          ang_vel = '0;
          age = '0;
        end
        OP_LIN_UP: begin
          lin_speed = raise_speed(lin_speed, cfg_lin_step, cfg_max_lin);
          age = '0;
        end
        OP_LIN_DOWN: begin
          lin_speed = lower_speed(lin_speed, cfg_lin_step);
          age = '0;
        end
        OP_ANG_UP: begin
          ang_speed = raise_speed(ang_speed, cfg_ang_step, cfg_max_ang);
          age = '0;
        end
        OP_ANG_DOWN: begin
          ang_speed = lower_speed(ang_speed, cfg_ang_step);
          age = '0;
        end
        OP_BEAM: begin
          if (w.beam_range_mm < cfg_safety) begin
            if (w.beam_index >= FRONT_FIRST && w.beam_index < FRONT_END) begin
              front_pend = 1'b1;
            end
            if (w.beam_index < REAR_HALF || w.beam_index >= BEAMS - REAR_HALF) begin
              rear_pend = 1'b1;
            end
          end
          if (w.beam_last) begin
            front_blk  = front_pend;
            rear_blk   = rear_pend;
            front_pend = 1'b0;
            rear_pend  = 1'b0;
            scan_seen  = 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_cmd(out_word_t got);
      out_word_t exp_w;
      if (due_cmds.size() == 0) begin
        errors++;
        $display("%0t: result word %h arrived with none due", $time, got);
        return;
      end
      exp_w = due_cmds.pop_front();
      if (got.linear_cmd !== exp_w.linear_cmd) begin
        errors++;
        $display("%0t: linear_cmd expected %0d, actual %0d", $time,
                 exp_w.linear_cmd, got.linear_cmd);
      end
      if (got.angular_cmd !== exp_w.angular_cmd) begin
        errors++;
        $display("%0t: angular_cmd expected %0d, actual %0d", $time,
                 exp_w.angular_cmd, got.angular_cmd);
      end
      if (got.unsafe_stop !== exp_w.unsafe_stop) begin
        errors++;
        $display("%0t: unsafe_stop expected %b, actual %b", $time,
                 exp_w.unsafe_stop, got.unsafe_stop);
      end
      if (got.timed_out !== exp_w.timed_out) begin
        errors++;
        $display("%0t: timed_out expected %b, actual %b", $time,
                 exp_w.timed_out, got.timed_out);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_word;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit         quiet;
  bit         hold_req;
  int         idle_cycles;
  cmd_tracker tracker;

  teleop_velocity_safety_gate u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        tracker.check_cmd(out_word);
      end
      if (in_valid && !in_stall) begin
        tracker.take_word(in_word);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("teleop_velocity_safety_gate verification failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  // The receiver either waits out a long hold-off on request or stalls the
  // result channel for a random number of cycles.
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_stall = 1'b1;
          repeat (n) @(negedge clk);
        end
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_word(input in_word_t w, input int gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_word  = w;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  function automatic in_word_t random_word(input logic [OP_W-1:0] op);
    in_word_t w;
    w.op            = op;
    w.beam_index    = BEAM_IDX_W'($urandom);
    w.beam_range_mm = RANGE_W'($urandom);
    w.beam_last     = 1'($urandom);
    return w;
  endfunction

  task automatic send_op(input logic [OP_W-1:0] op, input int idx, input int rng,
                         input bit last);
    in_word_t w;
    w = random_word(op);
    if (op == OP_BEAM) begin
      w.beam_index    = BEAM_IDX_W'(idx);
      w.beam_range_mm = RANGE_W'(rng);
      w.beam_last     = last;
    end
    send_word(w, gap_len());
  endtask

  // Beam words aim mostly at the sectors and their edges, with ranges
  // clustered around the safety distance.
  function automatic in_word_t beam_word(input bit last);
    in_word_t w;
    int       sd;
    w  = random_word(OP_BEAM);
    sd = int'(tracker.cfg_safety);
    case ($urandom_range(0, 3))
      0: w.beam_index = BEAM_IDX_W'($urandom_range(FRONT_FIRST, FRONT_END - 1));
      1: begin
        if ($urandom_range(0, 1)) begin
          w.beam_index = BEAM_IDX_W'($urandom_range(0, REAR_HALF - 1));
        end else begin
          w.beam_index = BEAM_IDX_W'($urandom_range(BEAMS - REAR_HALF, BEAMS - 1));
        end
      end
      2: begin
        case ($urandom_range(0, 7))
          0: w.beam_index = BEAM_IDX_W'(FRONT_FIRST - 1);
          1: w.beam_index = BEAM_IDX_W'(FRONT_FIRST);
          2: w.beam_index = BEAM_IDX_W'(FRONT_END - 1);
          3: w.beam_index = BEAM_IDX_W'(FRONT_END);
          4: w.beam_index = BEAM_IDX_W'(REAR_HALF - 1);
          5: w.beam_index = BEAM_IDX_W'(REAR_HALF);
          6: w.beam_index = BEAM_IDX_W'(BEAMS - REAR_HALF - 1);
          default: w.beam_index = BEAM_IDX_W'(BEAMS - REAR_HALF);
        endcase
      end
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: w.beam_range_mm = '0;
      1: w.beam_range_mm = '1;
      2: w.beam_range_mm = RANGE_W'((sd == 0) ? 0 : sd - 1);
      3: w.beam_range_mm = RANGE_W'(sd);
      4: ;
      default: w.beam_range_mm =
        RANGE_W'($urandom_range(0, (2 * sd + 1 > 65535) ? 65535 : 2 * sd + 1));
    endcase
    w.beam_last = last;
    return w;
  endfunction

  task automatic wait_idle();
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int d);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_DATA_W'(d);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.set_reg(idx, CFG_DATA_W'(d));
    @(negedge clk);
  endtask

  task automatic program_phase(input int p);
    int tmo;
    int mlin;
    int mang;
    int slin;
    int sang;
    int sd;
    case (p)
      1: begin
        tmo = 0; mlin = 0; mang = 0; slin = 1; sang = 1; sd = 0;
      end
      2: begin
        tmo = 255; mlin = 1000; mang = 1000; slin = 1000; sang = 1000; sd = 65535;
      end
      3: begin
        tmo = 3; mlin = 997; mang = 1000; slin = 100; sang = 7; sd = 1500;
      end
      default: begin
        tmo  = $urandom_range(0, 14);
        mlin = $urandom_range(0, 1000);
        mang = $urandom_range(0, 1000);
        slin = $urandom_range(0, 1) ? $urandom_range(1, 80) : $urandom_range(1, 1000);
        sang = $urandom_range(0, 1) ? $urandom_range(1, 80) : $urandom_range(1, 1000);
        sd   = $urandom_range(0, 1) ? $urandom_range(200, 3000) : $urandom_range(0, 65535);
      end
    endcase
    write_reg(CFG_TIMEOUT_TICKS, tmo);
    write_reg(CFG_MAX_LINEAR, mlin);
    write_reg(CFG_MAX_ANGULAR, mang);
    write_reg(CFG_LINEAR_STEP, slin);
    write_reg(CFG_ANGULAR_STEP, sang);
    write_reg(CFG_SAFETY_DIST, sd);
    cfg_valid = 1'b0;
  endtask

  task automatic run_directed();
    send_op(OP_TICK, 0, 0, 1'b0);
    send_op(OP_LIN_UP, 0, 0, 1'b0);
    send_op(OP_TICK, 0, 0, 1'b0);
    send_op(OP_BEAM, 0, 0, 1'b0);
    send_op(OP_BEAM, 64, 499, 1'b0);
    send_op(OP_BEAM, FRONT_END, 0, 1'b0);
    send_op(OP_BEAM, BEAMS - 1, 65535, 1'b1);
    send_op(OP_FWD, 0, 0, 1'b0);
    send_op(OP_TICK, 0, 0, 1'b0);
    send_op(OP_BACK, 0, 0, 1'b0);
    send_op(OP_TICK, 0, 0, 1'b0);
    send_op(OP_BEAM, FRONT_FIRST - 1, 0, 1'b1);
    send_op(OP_ANG_UP, 0, 0, 1'b0);
    send_op(OP_CW, 0, 0, 1'b0);
    send_op(OP_TICK, 0, 0, 1'b0);
    send_op(OP_CCW, 0, 0, 1'b0);
    send_op(OP_TICK, 0, 0, 1'b0);
    send_op(OP_ANG_DOWN, 0, 0, 1'b0);
    send_op(OP_LIN_DOWN, 0, 0, 1'b0);
    send_op(OP_LIN_DOWN, 0, 0, 1'b0);
    send_op(4'd11, 0, 0, 1'b0);
    send_op(4'd15, 0, 0, 1'b0);
    send_op(OP_STOP, 0, 0, 1'b0);
    send_op(OP_TICK, 0, 0, 1'b0);
    send_op(OP_BEAM, BEAMS - REAR_HALF, 499, 1'b1);
  endtask

  // Random traffic comes in runs: runs of beams that mostly end in a last beam,
  // groups of commands, strings of ticks, single mixed words and ignored opcodes.
  task automatic run_random(input int n);
    int               done;
    int               len;
    int               k;
    logic [OP_W-1:0]  op;
    done = 0;
    while (done < n) begin
      if ($urandom_range(0, 11) == 0) begin
        quiet = !quiet;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          len = $urandom_range(1, 24);
          for (k = 0; k < len; k++) begin
            if (k == len - 1) begin
              send_word(beam_word($urandom_range(0, 3) != 0), gap_len());
            end else begin
              send_word(beam_word($urandom_range(0, 29) == 0), gap_len());
            end
          end
          done += len;
        end
        3, 4: begin
          len = $urandom_range(1, 6);
          for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 2) == 0) begin
              op = $urandom_range(0, 1) ? OP_LIN_UP : OP_ANG_UP;
            end else begin
              op = OP_W'($urandom_range(OP_FWD, OP_ANG_DOWN));
            end
            send_word(random_word(op), gap_len());
          end
          done += len;
        end
        5, 6: begin
          len = $urandom_range(1, 14);
          for (k = 0; k < len; k++) begin
            send_word(random_word(OP_TICK), gap_len());
          end
          done += len;
        end
        7, 8: begin
          op = OP_W'($urandom_range(OP_TICK, OP_BEAM));
          if (op == OP_BEAM) begin
            send_word(beam_word(1'($urandom_range(0, 1))), gap_len());
          end else begin
            send_word(random_word(op), gap_len());
          end
          done++;
        end
        default: begin
          send_word(random_word(OP_W'($urandom_range(11, 15))), gap_len());
          done++;
        end
      endcase
    end
  endtask

  // The receiver holds off while ticks keep coming, so the gate fills and
  // stalls its input; the sender then waits for every result word.
  task automatic apply_pressure();
    int k;
    in_valid = 1'b0;
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    for (k = 0; k < 24; k++) begin
      send_word(random_word(OP_TICK), 0);
    end
    wait_idle();
  endtask

  initial begin
    int p;
    tracker   = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TIMEOUT_TICKS;
    cfg_data  = '0;
    quiet     = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    run_directed();
    for (p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        program_phase(p);
      end
      if (p == 4) begin
        apply_pressure();
      end
      run_random(ITEMS_PER_PHASE);
    end
    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("teleop_velocity_safety_gate verification clean");
    end else begin
      $display("teleop_velocity_safety_gate verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/tvsg_pkg.sv
sv/tvsg_cfg_regs.sv
sv/tvsg_state.sv
sv/teleop_velocity_safety_gate.sv
sim/testbench.sv
